### src/tws_pkg.sv
`timescale 1ns / 1ps

package tws_pkg;

    // Default data block size in bytes
    localparam int TWS_BLOCK_BYTES = 512;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SERVER_PORT  = 2'd0,
        REG_REQ_TIMEOUT  = 2'd1,
        REG_ACK_TIMEOUT  = 2'd2,
        REG_MAX_ATTEMPTS = 2'd3
    } reg_idx_t;

    // Configuration reset values
    localparam logic [15:0] SERVER_PORT_RST  = 16'd1069;
    localparam logic [7:0]  REQ_TIMEOUT_RST  = 8'd5;
    localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd3;
    localparam logic [2:0]  MAX_ATTEMPTS_RST = 3'd4;

    // Input item kinds
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_PKT   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Result actions
    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_WRQ      = 2'd1,
        ACT_DATA     = 2'd2,
        ACT_RESEND   = 2'd3
    } action_t;

    // Reported status
    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_BUSY       = 3'd1,
        ST_DONE       = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_NO_ANSWER  = 3'd4,
        ST_TIMEOUT    = 3'd5
    } status_t;

    // Transfer phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_ACK0 = 3'd1,
        PH_SENDING   = 3'd2,
        PH_DONE      = 3'd3,
        PH_EMPTY     = 3'd4,
        PH_NO_ANSWER = 3'd5,
        PH_TIMEOUT   = 3'd6
    } phase_t;

    localparam logic [15:0] OPCODE_ACK = 16'd4;
    localparam logic [9:0]  ACK_LEN    = 10'd4;

    // Payload widths
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 112;

    function automatic status_t phase_status(input phase_t ph);
        status_t st;
        case (ph)
            PH_WAIT_ACK0, PH_SENDING: st = ST_BUSY;
            PH_DONE:                  st = ST_DONE;
            PH_EMPTY:                 st = ST_EMPTY;
            PH_NO_ANSWER:             st = ST_NO_ANSWER;
            PH_TIMEOUT:               st = ST_TIMEOUT;
            default:                  st = ST_IDLE;
        endcase
        return st;
    endfunction

endpackage

### src/tftp_write_sender.sv
`timescale 1ns / 1ps

// TFTP write sender control. Each input item (start, one-second tick or the
// decoded header of a received packet) yields exactly one result item that
// says which packet to send next (write request, data block, resend) along
// with the current status and the byte count acknowledged so far. An item is
// taken every cycle while s_tready is high; the transfer state updates in
// the cycle of acceptance and the result is registered. Results go through a
// two-entry output stage (main register plus skid register), so s_tready only
// drops when both entries hold results the sink has not yet taken. Block
// lengths and offsets are tracked incrementally (bytes remaining, next offset)
// so no divider is needed for any BLOCK_BYTES. Configuration registers must
// only be written while no transfer result is pending.
module tftp_write_sender
    import tws_pkg::*;
#(
    parameter int BLOCK_BYTES = TWS_BLOCK_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata,

    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // target_ip[31:0], file_size[63:32], src_addr[95:64], src_port[111:96],
    // pkt_len[121:112], pkt_opcode[137:122], pkt_block[153:138], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]            s_tuser,

    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dest_port[15:0], block_number[31:16], data_offset[63:32],
    // data_len[73:64], status[76:74], bytes_acked[108:77], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // action[1:0]
    output logic [1:0]            m_tuser
);

    localparam logic [31:0] BLK = 32'(BLOCK_BYTES);

    // Configuration
    logic [15:0] server_port_reg;
    logic [7:0]  req_timeout_reg;
    logic [7:0]  ack_timeout_reg;
    logic [2:0]  max_attempts_reg;

    // Transfer state
    phase_t      phase_reg,       phase_next;
    logic [15:0] cur_block_reg,   cur_block_next;
    logic [2:0]  attempts_reg,    attempts_next;
    logic [7:0]  ticks_reg,       ticks_next;
    logic [31:0] remote_addr_reg, remote_addr_next;
    logic [15:0] remote_port_reg, remote_port_next;
    logic [31:0] remain_reg,      remain_next;   // bytes not yet in a full acked block
    logic [31:0] offset_reg,      offset_next;   // offset of the current block
    logic [31:0] acked_reg,       acked_next;
    action_t     act;

    // Output stage
    logic                  main_valid_reg;
    logic                  skid_valid_reg;
    logic [OUT_DATA_W-1:0] main_data_reg, skid_data_reg;
    logic [1:0]            main_user_reg, skid_user_reg;

    // Input fields
    cmd_t        cmd;
    logic [31:0] in_target_ip;
    logic [31:0] in_file_size;
    logic [31:0] in_src_addr;
    logic [15:0] in_src_port;
    logic [9:0]  in_pkt_len;
    logic [15:0] in_pkt_opcode;
    logic [15:0] in_pkt_block;

    assign cmd           = cmd_t'(s_tuser);
    assign in_target_ip  = s_tdata[31:0];
    assign in_file_size  = s_tdata[63:32];
    assign in_src_addr   = s_tdata[95:64];
    assign in_src_port   = s_tdata[111:96];
    assign in_pkt_len    = s_tdata[121:112];
    assign in_pkt_opcode = s_tdata[137:122];
    assign in_pkt_block  = s_tdata[153:138];

    logic accept;
    logic pop;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = main_valid_reg && m_tready;

    // Length of the block at the current position
    logic [31:0] cur_len;
    logic        cur_full;
    assign cur_full = (remain_reg >= BLK);
    assign cur_len  = cur_full ? BLK : remain_reg;

    logic is_ack;
    assign is_ack = (in_pkt_len == ACK_LEN) && (in_pkt_opcode == OPCODE_ACK)
                 && (in_src_addr == remote_addr_reg);

    // Next state
    always_comb begin
        phase_next       = phase_reg;
        cur_block_next   = cur_block_reg;
        attempts_next    = attempts_reg;
        ticks_next       = ticks_reg;
        remote_addr_next = remote_addr_reg;
        remote_port_next = remote_port_reg;
        remain_next      = remain_reg;
        offset_next      = offset_reg;
        acked_next       = acked_reg;
        act              = ACT_NONE;

        case (cmd)
            CMD_START: begin
                remote_addr_next = in_target_ip;
                remain_next      = in_file_size;
                offset_next      = '0;
                acked_next       = '0;
                cur_block_next   = '0;
                attempts_next    = '0;
                ticks_next       = '0;
                remote_port_next = server_port_reg;
                if (in_file_size == '0) begin
                    phase_next = PH_EMPTY;
                end else begin
                    phase_next = PH_WAIT_ACK0;
                    ticks_next = req_timeout_reg;
                    act        = ACT_WRQ;
                end
            end
            CMD_TICK: begin
                if (phase_reg == PH_WAIT_ACK0) begin
                    if (ticks_reg <= 8'd1) begin
                        ticks_next = '0;
                        phase_next = PH_NO_ANSWER;
                    end else begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end else if (phase_reg == PH_SENDING) begin
                    if (ticks_reg <= 8'd1) begin
                        if (attempts_reg <= 3'd1) begin
                            attempts_next = '0;
                            ticks_next    = '0;
                            phase_next    = PH_TIMEOUT;
                        end else begin
                            attempts_next = attempts_reg - 3'd1;
                            ticks_next    = ack_timeout_reg;
                            act           = ACT_RESEND;
                        end
                    end else begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end
            end
            CMD_PKT: begin
                if (phase_reg == PH_WAIT_ACK0) begin
                    // ACK 0 must come from a fresh port, not the server port
                    if (is_ack && in_pkt_block == '0
                            && in_src_port != remote_port_reg) begin
                        remote_port_next = in_src_port;
                        phase_next       = PH_SENDING;
                        cur_block_next   = 16'd1;
                        attempts_next    = max_attempts_reg;
                        ticks_next       = ack_timeout_reg;
                        act              = ACT_DATA;
                    end
                end else if (phase_reg == PH_SENDING) begin
                    if (is_ack && in_src_port == remote_port_reg
                            && in_pkt_block == cur_block_reg) begin
                        acked_next = acked_reg + cur_len;
                        if (cur_full) begin
                            remain_next    = remain_reg - BLK;
                            offset_next    = offset_reg + BLK;
                            cur_block_next = cur_block_reg + 16'd1;
                            attempts_next  = max_attempts_reg;
                            ticks_next     = ack_timeout_reg;
                            act            = ACT_DATA;
                        end else begin
                            ticks_next    = '0;
                            attempts_next = '0;
                            phase_next    = PH_DONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result item
    logic [15:0] res_dest_port;
    logic [15:0] res_block;
    logic [31:0] res_offset;
    logic [9:0]  res_len;
    logic [31:0] nxt_len;
    logic [OUT_DATA_W-1:0] res_data;

    assign nxt_len = (remain_next >= BLK) ? BLK : remain_next;

    always_comb begin
        res_dest_port = '0;
        res_block     = '0;
        res_offset    = '0;
        res_len       = '0;
        case (act)
            ACT_WRQ: begin
                res_dest_port = remote_port_next;
            end
            ACT_DATA, ACT_RESEND: begin
                res_dest_port = remote_port_next;
                res_block     = cur_block_next;
                res_offset    = offset_next;
                res_len       = nxt_len[9:0];
            end
            default: begin
            end
        endcase
        res_data = {3'b000, acked_next, phase_status(phase_next),
                    res_len, res_offset, res_block, res_dest_port};
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_port_reg  <= SERVER_PORT_RST;
            req_timeout_reg  <= REQ_TIMEOUT_RST;
            ack_timeout_reg  <= ACK_TIMEOUT_RST;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_SERVER_PORT:  server_port_reg  <= cfg_wdata;
                REG_REQ_TIMEOUT:  req_timeout_reg  <= cfg_wdata[7:0];
                REG_ACK_TIMEOUT:  ack_timeout_reg  <= cfg_wdata[7:0];
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // Transfer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            cur_block_reg   <= '0;
            attempts_reg    <= '0;
            ticks_reg       <= '0;
            remote_addr_reg <= '0;
            remote_port_reg <= '0;
            remain_reg      <= '0;
            offset_reg      <= '0;
            acked_reg       <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            cur_block_reg   <= cur_block_next;
            attempts_reg    <= attempts_next;
            ticks_reg       <= ticks_next;
            remote_addr_reg <= remote_addr_next;
            remote_port_reg <= remote_port_next;
            remain_reg      <= remain_next;
            offset_reg      <= offset_next;
            acked_reg       <= acked_next;
        end
    end

    // Output stage: main register feeds the port, skid catches a result
    // accepted while main is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (!main_valid_reg || pop) begin
                    main_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                main_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!main_valid_reg || pop) begin
                main_data_reg <= res_data;
                main_user_reg <= act;
            end else begin
                skid_data_reg <= res_data;
                skid_user_reg <= act;
            end
        end else if (pop && skid_valid_reg) begin
            main_data_reg <= skid_data_reg;
            main_user_reg <= skid_user_reg;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_data_reg;
    assign m_tuser  = main_user_reg;

endmodule
